// ===== src/cdfd_pkg.sv =====
// Shared widths, calendar constants and the March-based month table for the
// civil date converter. No dependencies.
package cdfd_pkg;

  // Port field widths.
  localparam int DAY_W   = 32;
  localparam int YEAR_W  = 24;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int WDAY_W  = 3;

  // Internal value widths.
  localparam int T_W   = DAY_W + 1;  // biased day count, never negative
  localparam int ERA_W = 15;         // biased era index, at most 29399
  localparam int REM_W = 19;         // era remainder before correction
  localparam int DOE_W = 18;         // day of era, 0..146096
  localparam int YOE_W = 9;          // year of era, 0..399
  localparam int DOY_W = 9;          // day of March-based year, 0..365
  localparam int MP_W  = 4;          // March-based month, 0..11

  // Calendar constants.
  localparam int unsigned ERA_DAYS       = 146097;
  localparam int unsigned CENTURY_DAYS   = 36524;
  localparam int unsigned QUAD_YEAR_DAYS = 1460;
  localparam int unsigned YEAR_DAYS      = 365;
  localparam int unsigned YEARS_PER_ERA  = 400;
  localparam int unsigned YEARS_PER_CENT = 100;
  localparam int unsigned DAYS_PER_WEEK  = 7;
  localparam int unsigned MONTHS_PER_YEAR = 12;
  localparam int unsigned FEBRUARY       = 2;
  localparam int unsigned FEB_MAX_DAYS   = 29;
  localparam int unsigned WEEKDAY_MAX    = 6;
  localparam int unsigned JAN_MP         = 10;  // January in the March-based year
  localparam int unsigned MONTH_FROM_MP  = 3;   // month = mp + 3 before January
  localparam int unsigned MONTH_WRAP_MP  = 9;   // month = mp - 9 from January on

  // The day count is biased by 2^31 (sign flip) plus EPOCH_OFFSET. The total bias
  // equals 719468 (days from 0000-03-01 to 1970-01-01) plus ERA_BIAS whole eras,
  // so the biased value is never negative and floor division becomes plain division.
  localparam int unsigned ERA_BIAS     = 14695;
  localparam int unsigned EPOCH_OFFSET = 131235;

  // Weekday of a day of era: (doe + WEEKDAY_BIAS) mod 7, since an era is whole weeks.
  localparam int unsigned WEEKDAY_BIAS = 3;

  // Floor reciprocal of the era length; applied to the biased count shifted by 7.
  localparam int ERA_PRE_SHIFT   = 7;
  localparam int ERA_RECIP_SHIFT = 39;
  localparam int ERA_RECIP_W     = 22;
  localparam logic [ERA_RECIP_W-1:0] ERA_RECIP =
    ERA_RECIP_W'((64'd1 << ERA_RECIP_SHIFT) / 64'(ERA_DAYS));

  // Day on which each March-based month starts, (153 * mp + 2) / 5.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] start;
    case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ===== src/civil_date_from_day_count_unit.sv =====
// Top level of the civil date converter: a ten-stage pipeline from a signed day
// count to year, month, day and weekday. Uses cdfd_pkg and cdfd_const_div.
//
// Usage
//   A request carries day_count, the signed number of days since 1970-01-01. It is
//   taken at a rising edge of clk with day_valid high and day_stall low. The result
//   (proleptic Gregorian year, month 1..12, day_of_month 1..31 and weekday with
//   0 for Sunday) is offered on date_valid and taken at an edge with date_stall low.
//   Every request gives exactly one result, in request order.
// Pipeline and throughput
//   A result is offered on date_valid from stage ten, the output register. While
//   date_stall is low, one request can enter in every cycle. The stages are the
//   bias, the era division (estimate, remainder, correction), the leap-day
//   quotients and their subtraction, the year-of-era division, the day of year,
//   the month lookup and the output, each closed by a register.
// Stalls
//   Every stage has a valid bit and loads when it is empty or when the stage after
//   it moves. While date_stall holds a result, earlier empty stages keep filling;
//   day_stall rises only once all ten stages hold requests.
// Reset
//   rst is synchronous and active high. It empties the pipeline; in the cycle after
//   reset date_valid is low and day_stall is low.
module civil_date_from_day_count_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             day_valid,
  output logic                             day_stall,
  input  logic signed [cdfd_pkg::DAY_W-1:0] day_count,
  output logic                             date_valid,
  input  logic                             date_stall,
  output logic signed [cdfd_pkg::YEAR_W-1:0] year,
  output logic [cdfd_pkg::MONTH_W-1:0]     month,
  output logic [cdfd_pkg::DOM_W-1:0]       day_of_month,
  output logic [cdfd_pkg::WDAY_W-1:0]      weekday
);

  import cdfd_pkg::*;

  localparam int NSTAGE = 10;

  // Pipeline control: one valid bit per stage and a ready chain from the output.
  logic [NSTAGE:1]   vld;
  logic [NSTAGE:1]   vld_in;
  logic [NSTAGE+1:1] rdy;

  assign vld_in          = {vld[NSTAGE-1:1], day_valid};
  assign rdy[NSTAGE+1]   = !date_stall;

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_ctrl
    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld_in[k];
      end
    end
  end

  assign day_stall  = !rdy[1];
  assign date_valid = vld[NSTAGE];

  // Stage 1: bias the day count so that the era index is a plain quotient.
  logic [T_W-1:0] s1_t;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_t <= {1'b0, ~day_count[DAY_W-1], day_count[DAY_W-2:0]} + T_W'(EPOCH_OFFSET);
    end
  end

  // Stage 2: estimate the era from the top bits. The estimate is the true quotient
  // or one below it.
  localparam int ERA_PW = T_W - ERA_PRE_SHIFT + ERA_RECIP_W;

  logic [ERA_PW-1:0] s2_p;
  logic [T_W-1:0]    s2_t;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_p <= ERA_PW'(s1_t[T_W-1:ERA_PRE_SHIFT]) * ERA_PW'(ERA_RECIP);
      s2_t <= s1_t;
    end
  end

  // Stage 3: remainder against the estimate; it stays below two era lengths.
  logic [ERA_W-1:0] q0;
  logic [T_W-1:0]   r0_full;
  logic [ERA_W-1:0] s3_q0;
  logic [REM_W-1:0] s3_r0;

  assign q0      = s2_p[ERA_RECIP_SHIFT - ERA_PRE_SHIFT +: ERA_W];
  assign r0_full = s2_t - T_W'(q0) * T_W'(ERA_DAYS);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_q0 <= q0;
      s3_r0 <= r0_full[REM_W-1:0];
    end
  end

  // Stage 4: one correction step gives the exact era and day of era.
  logic [DOE_W-1:0] s4_doe;
  logic [ERA_W-1:0] s4_eq;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      if (s3_r0 >= REM_W'(ERA_DAYS)) begin
        s4_doe <= DOE_W'(s3_r0 - REM_W'(ERA_DAYS));
        s4_eq  <= s3_q0 + ERA_W'(1);
      end else begin
        s4_doe <= s3_r0[DOE_W-1:0];
        s4_eq  <= s3_q0;
      end
    end
  end

  // Stage 5: leap-day corrections of the day of era, first year of the era, and
  // the quotient for the weekday.
  logic signed [ERA_W:0]  era;
  logic [2:0]             n_cent;
  logic [DOE_W-1:0]       s5_doe;
  logic [YEAR_W-1:0]      s5_e400;
  logic [2:0]             s5_n_cent;
  logic                   s5_full;
  logic [6:0]             s5_q_quad;
  logic [14:0]            s5_q_week;

  assign era    = signed'((ERA_W+1)'(s4_eq) - (ERA_W+1)'(ERA_BIAS));
  assign n_cent = 3'(s4_doe >= DOE_W'(CENTURY_DAYS))
                + 3'(s4_doe >= DOE_W'(2 * CENTURY_DAYS))
                + 3'(s4_doe >= DOE_W'(3 * CENTURY_DAYS))
                + 3'(s4_doe >= DOE_W'(ERA_DAYS - 1));

  cdfd_const_div #(
    .W_IN (DOE_W),
    .W_Q  (7),
    .DIV  (QUAD_YEAR_DAYS),
    .SHIFT(29)
  ) u_div_quad (
    .clk(clk),
    .en (rdy[5]),
    .x  (s4_doe),
    .q  (s5_q_quad)
  );

  cdfd_const_div #(
    .W_IN (DOE_W),
    .W_Q  (15),
    .DIV  (DAYS_PER_WEEK),
    .SHIFT(21)
  ) u_div_week (
    .clk(clk),
    .en (rdy[5]),
    .x  (s4_doe + DOE_W'(WEEKDAY_BIAS)),
    .q  (s5_q_week)
  );

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_doe    <= s4_doe;
      s5_e400   <= YEAR_W'(era) * YEAR_W'(YEARS_PER_ERA);
      s5_n_cent <= n_cent;
      s5_full   <= (s4_doe == DOE_W'(ERA_DAYS - 1));
    end
  end

  // Stage 6: day of era with leap days taken out, and the weekday remainder.
  logic [DOE_W-1:0]  s6_yn;
  logic [DOE_W-1:0]  s6_doe;
  logic [YEAR_W-1:0] s6_e400;
  logic [WDAY_W-1:0] s6_wd;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_yn   <= s5_doe - DOE_W'(s5_q_quad) + DOE_W'(s5_n_cent) - DOE_W'(s5_full);
      s6_wd   <= WDAY_W'((s5_doe + DOE_W'(WEEKDAY_BIAS))
                         - DOE_W'(s5_q_week) * DOE_W'(DAYS_PER_WEEK));
      s6_doe  <= s5_doe;
      s6_e400 <= s5_e400;
    end
  end

  // Stage 7: year of era.
  logic [YOE_W-1:0]  s7_yoe;
  logic [DOE_W-1:0]  s7_doe;
  logic [YEAR_W-1:0] s7_e400;
  logic [WDAY_W-1:0] s7_wd;

  cdfd_const_div #(
    .W_IN (DOE_W),
    .W_Q  (YOE_W),
    .DIV  (YEAR_DAYS),
    .SHIFT(27)
  ) u_div_year (
    .clk(clk),
    .en (rdy[7]),
    .x  (s6_yn),
    .q  (s7_yoe)
  );

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_doe  <= s6_doe;
      s7_e400 <= s6_e400;
      s7_wd   <= s6_wd;
    end
  end

  // Stage 8: day of the March-based year.
  logic [1:0]        n_yr_cent;
  logic [DOE_W-1:0]  year_base;
  logic [DOY_W-1:0]  s8_doy;
  logic [YOE_W-1:0]  s8_yoe;
  logic [YEAR_W-1:0] s8_e400;
  logic [WDAY_W-1:0] s8_wd;

  assign n_yr_cent = 2'(s7_yoe >= YOE_W'(YEARS_PER_CENT))
                   + 2'(s7_yoe >= YOE_W'(2 * YEARS_PER_CENT))
                   + 2'(s7_yoe >= YOE_W'(3 * YEARS_PER_CENT));
  assign year_base = DOE_W'(s7_yoe) * DOE_W'(YEAR_DAYS)
                   + DOE_W'(s7_yoe[YOE_W-1:2]) - DOE_W'(n_yr_cent);

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      s8_doy  <= DOY_W'(s7_doe - year_base);
      s8_yoe  <= s7_yoe;
      s8_e400 <= s7_e400;
      s8_wd   <= s7_wd;
    end
  end

  // Stage 9: March-based month by comparing against the month start table.
  logic [MP_W-1:0]   mp_c;
  logic [MP_W-1:0]   s9_mp;
  logic [DOY_W-1:0]  s9_doy;
  logic [YOE_W-1:0]  s9_yoe;
  logic [YEAR_W-1:0] s9_e400;
  logic [WDAY_W-1:0] s9_wd;

  always_comb begin
    mp_c = '0;
    for (int k = 1; k < MONTHS_PER_YEAR; k++) begin
      mp_c = mp_c + MP_W'(s8_doy >= month_start(MP_W'(k)));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      s9_mp   <= mp_c;
      s9_doy  <= s8_doy;
      s9_yoe  <= s8_yoe;
      s9_e400 <= s8_e400;
      s9_wd   <= s8_wd;
    end
  end

  // Stage 10: output register. January and February belong to the next
  // calendar year of a March-based year.
  logic in_next_year;

  assign in_next_year = (s9_mp >= MP_W'(JAN_MP));

  always_ff @(posedge clk) begin
    if (rdy[10]) begin
      year         <= s9_e400 + YEAR_W'(s9_yoe) + YEAR_W'(in_next_year);
      month        <= in_next_year ? MONTH_W'(s9_mp - MP_W'(MONTH_WRAP_MP))
                                   : MONTH_W'(s9_mp + MP_W'(MONTH_FROM_MP));
      day_of_month <= DOM_W'(s9_doy - month_start(s9_mp) + DOY_W'(1));
      weekday      <= s9_wd;
    end
  end

endmodule

// ===== src/cdfd_const_div.sv =====
// Registered division of an unsigned value by a constant, done as a multiply by a
// rounded-up reciprocal and a shift. Stand-alone; no package needed.
module cdfd_const_div #(
  parameter int          W_IN  = 18,
  parameter int          W_Q   = 8,
  parameter int unsigned DIV   = 7,
  parameter int          SHIFT = 21
) (
  input  logic            clk,
  input  logic            en,
  input  logic [W_IN-1:0] x,
  output logic [W_Q-1:0]  q
);

  // Exact for every x below 2^W_IN as long as SHIFT >= W_IN + clog2(DIV).
  localparam longint unsigned MULT = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam int MW = $clog2(MULT + 1);
  localparam int PW = W_IN + MW;

  logic [PW-1:0] prod;

  assign prod = PW'(x) * PW'(MULT);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= prod[SHIFT +: W_Q];
    end
  end

endmodule

// ===== src/cdfd_checker.sv =====
// Port-level checks for the civil date converter, bound to its top level.
// Uses cdfd_pkg for field widths and calendar limits.
module cdfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              day_valid,
  input logic                              day_stall,
  input logic                              date_valid,
  input logic                              date_stall,
  input logic signed [cdfd_pkg::YEAR_W-1:0] year,
  input logic [cdfd_pkg::MONTH_W-1:0]      month,
  input logic [cdfd_pkg::DOM_W-1:0]        day_of_month,
  input logic [cdfd_pkg::WDAY_W-1:0]       weekday
);

  import cdfd_pkg::*;

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !date_valid && !day_stall)
    else $error("pipeline not empty after reset");

  // Requests are only held back when the output is full and stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    day_stall |-> date_valid && date_stall)
    else $error("request stalled while the output can move");

  // A stalled result stays put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    date_valid && date_stall |=> date_valid && $stable(year) && $stable(month)
                                 && $stable(day_of_month) && $stable(weekday))
    else $error("stalled result changed");

  // Every delivered date: month 1..12, day >= 1, day <= 29 in February.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    date_valid && !day_valid |-> 1'b1 ##0
    (month >= MONTH_W'(1) && month <= MONTH_W'(MONTHS_PER_YEAR)
     && day_of_month >= DOM_W'(1) && weekday <= WDAY_W'(WEEKDAY_MAX)
     && (month != MONTH_W'(FEBRUARY) || day_of_month <= DOM_W'(FEB_MAX_DAYS))))
    else $error("result is not a valid date");

  a_date_range_any: assert property (@(posedge clk) disable iff (rst)
    date_valid |->
    (month >= MONTH_W'(1) && month <= MONTH_W'(MONTHS_PER_YEAR)
     && day_of_month >= DOM_W'(1) && weekday <= WDAY_W'(WEEKDAY_MAX)
     && (month != MONTH_W'(FEBRUARY) || day_of_month <= DOM_W'(FEB_MAX_DAYS))))
    else $error("result is not a valid date");

endmodule

bind civil_date_from_day_count_unit cdfd_checker u_cdfd_checker (
  .clk         (clk),
  .rst         (rst),
  .day_valid   (day_valid),
  .day_stall   (day_stall),
  .date_valid  (date_valid),
  .date_stall  (date_stall),
  .year        (year),
  .month       (month),
  .day_of_month(day_of_month),
  .weekday     (weekday)
);

// ===== test/civil_date_checker.sv =====
// Scoreboard for the civil date converter: predicts year, month, day and weekday
// from each accepted request and compares them with the results in order.
// Uses cdfd_pkg for the port widths.
module civil_date_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               day_valid,
  input  logic                               day_stall,
  input  logic signed [cdfd_pkg::DAY_W-1:0]  day_count,
  input  logic                               date_valid,
  input  logic                               date_stall,
  input  logic signed [cdfd_pkg::YEAR_W-1:0] year,
  input  logic [cdfd_pkg::MONTH_W-1:0]       month,
  input  logic [cdfd_pkg::DOM_W-1:0]         day_of_month,
  input  logic [cdfd_pkg::WDAY_W-1:0]        weekday,
  output int                                 fail_count,
  output int                                 pending
);

  localparam longint EPOCH_TO_MARCH_ZERO = 719468;  // 0000-03-01 to 1970-01-01
  localparam longint ERA_LEN             = 146097;
  localparam longint CENT_LEN            = 36524;
  localparam longint QUAD_LEN            = 1460;
  localparam longint YEAR_LEN            = 365;
  localparam longint FIVE_MONTH_DAYS     = 153;
  localparam longint WEEK_LEN            = 7;
  localparam longint EPOCH_WEEKDAY       = 4;       // 1970-01-01 was a Thursday
  localparam int     REPORT_LIMIT        = 10;

  typedef struct packed {
    logic signed [cdfd_pkg::DAY_W-1:0]  source;
    logic signed [cdfd_pkg::YEAR_W-1:0] year;
    logic [cdfd_pkg::MONTH_W-1:0]       month;
    logic [cdfd_pkg::DOM_W-1:0]         dom;
    logic [cdfd_pkg::WDAY_W-1:0]        wday;
  } civil_date_t;

  civil_date_t expected_dates[$];
  int          failures = 0;

  // Era and day-of-era split with floor division, then a March-based year.
  function automatic civil_date_t civil_from_day_count(
    input logic signed [cdfd_pkg::DAY_W-1:0] dc);
    civil_date_t d;
    longint days, shifted, era, doe, yoe, doy, mp, mon, yr, wd;
    days    = dc;
    shifted = days + EPOCH_TO_MARCH_ZERO;
    era     = (shifted >= 0 ? shifted : shifted - (ERA_LEN - 1)) / ERA_LEN;
    doe     = shifted - era * ERA_LEN;
    yoe     = (doe - doe / QUAD_LEN + doe / CENT_LEN - doe / (ERA_LEN - 1)) / YEAR_LEN;
    doy     = doe - (YEAR_LEN * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy + 2) / FIVE_MONTH_DAYS;
    mon     = (mp < 10) ? mp + 3 : mp - 9;
    yr      = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    wd      = (days + EPOCH_WEEKDAY) % WEEK_LEN;
    if (wd < 0) wd += WEEK_LEN;
    d.source = dc;
    d.year   = yr[cdfd_pkg::YEAR_W-1:0];
    d.month  = mon[cdfd_pkg::MONTH_W-1:0];
    d.dom    = 5'(doy - (FIVE_MONTH_DAYS * mp + 2) / 5 + 1);
    d.wday   = wd[cdfd_pkg::WDAY_W-1:0];
    return d;
  endfunction

  always @(posedge clk) begin
    civil_date_t want;
    if (!rst) begin
      if (date_valid && !date_stall) begin
        if (expected_dates.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("unexpected result %0d-%0d-%0d wd %0d with no request waiting",
                     year, month, day_of_month, weekday);
        end else begin
          want = expected_dates.pop_front();
          if (want.year !== year || want.month !== month ||
              want.dom !== day_of_month || want.wday !== weekday) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("mismatch for day %0d: expected %0d-%0d-%0d wd %0d, got %0d-%0d-%0d wd %0d",
                       want.source, want.year, want.month, want.dom, want.wday,
                       year, month, day_of_month, weekday);
          end
        end
      end
      if (day_valid && !day_stall)
        expected_dates.push_back(civil_from_day_count(day_count));
    end
    fail_count <= failures;
    pending    <= expected_dates.size();
  end

endmodule

// ===== test/tb_civil_date_from_day_count_unit.sv =====
// Testbench top for civil_date_from_day_count_unit: drives directed and random
// day counts under several idle and stall patterns and gives the verdict.
// Depends on cdfd_pkg, the converter RTL and civil_date_checker.
module tb_civil_date_from_day_count_unit;

  // The converter is ten stages deep.
  localparam int DRAIN_CYCLES   = 20;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_REQUESTS = 170;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                               clk;
  logic                               rst;
  logic                               day_valid;
  logic                               day_stall;
  logic signed [cdfd_pkg::DAY_W-1:0]  day_count;
  logic                               date_valid;
  logic                               date_stall = 1'b0;
  logic signed [cdfd_pkg::YEAR_W-1:0] year;
  logic [cdfd_pkg::MONTH_W-1:0]       month;
  logic [cdfd_pkg::DOM_W-1:0]         day_of_month;
  logic [cdfd_pkg::WDAY_W-1:0]        weekday;

  int fail_count;
  int pending;
  int cycles = 0;
  int sender_idle_pct;
  int receiver_stall_pct;

  civil_date_from_day_count_unit dut (
    .clk          (clk),
    .rst          (rst),
    .day_valid    (day_valid),
    .day_stall    (day_stall),
    .day_count    (day_count),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday)
  );

  civil_date_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .day_valid    (day_valid),
    .day_stall    (day_stall),
    .day_count    (day_count),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .weekday      (weekday),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // The receiver stalls at random with the percentage of the current phase.
  // A fresh decision is made at every edge, so stalls land on every pipeline phase.
  always @(posedge clk) begin
    date_stall <= !rst && (int'($urandom_range(0, 99)) < receiver_stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one request. The sender may first idle for a random number of cycles.
  // Valid is left high after acceptance so that back-to-back requests never lower
  // and raise it within the same time step; an idling next call or the end lowers it.
  // Values read right after the edge are the ones that decided that edge.
  task automatic offer_day(input logic [cdfd_pkg::DAY_W-1:0] value);
    while (int'($urandom_range(0, 99)) < sender_idle_pct) begin
      day_valid <= 1'b0;
      @(posedge clk);
    end
    day_valid <= 1'b1;
    day_count <= value;
    do @(posedge clk); while (day_stall);
  endtask

  // Random day counts from several families. Full 32-bit patterns toggle every
  // input bit; the others aim at era starts, century and leap-year edges, the
  // range around 1970 and both ends of the signed range.
  function automatic logic [cdfd_pkg::DAY_W-1:0] pick_day();
    logic [cdfd_pkg::DAY_W-1:0] value;
    longint era, yoe, doe, offset;
    value = '0;
    case ($urandom_range(0, 4))
      0: value = $urandom();
      1: value = $urandom_range(0, 400000) - 200000;
      2: begin
        era   = longint'($urandom_range(0, 29000)) - 14500;
        value = 32'(era * 146097 - 719468 + longint'($urandom_range(0, 6)) - 3);
      end
      3: begin
        // Start of a year near a century, then a step to the year's end,
        // to New Year or to the leap day, give or take a couple of days.
        era = longint'($urandom_range(0, 40)) - 20;
        yoe = 100 * longint'($urandom_range(1, 4)) - longint'($urandom_range(0, 4));
        doe = 365 * yoe + yoe / 4 - yoe / 100;
        case ($urandom_range(0, 4))
          0:       offset = 0;
          1:       offset = 305;
          2:       offset = 306;
          3:       offset = 364;
          default: offset = 365;
        endcase
        offset = offset + longint'($urandom_range(0, 4)) - 2;
        value  = 32'(era * 146097 - 719468 + doe + offset);
      end
      default: begin
        if ($urandom_range(0, 1))
          value = 32'h7FFF_FFFF - $urandom_range(0, 1000);
        else
          value = 32'h8000_0000 + $urandom_range(0, 1000);
      end
    endcase
    return value;
  endfunction

  // Directed requests: both ends of the input range, the epoch and its
  // neighbors, 0000-03-01 and the leap day before it, the start of year zero, an
  // era boundary below zero, leap and non-leap century years, and late dates.
  int corner_days[$] = '{
    0, 1, -1,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE, 32'h8000_0001,
    -719468, -719469, -719528,
    -865565, -573372,
    10956, 10957, 11016, 11017,
    58, 59, 789,
    -25567, -25509, -25508,
    2932896
  };

  initial begin
    idle_mode_t mode;
    rst                = 1'b1;
    day_valid          = 1'b0;
    day_count          = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at full rate with no idling on either side.
    foreach (corner_days[i]) offer_day(corner_days[i]);

    // Random part: the idle pattern cycles through its four modes twice.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      mode = idle_mode_t'(ph % 4);
      case (mode)
        IDLE_NONE: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct    = 68;
          receiver_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 68;
        end
        default: begin
          sender_idle_pct    = 24;
          receiver_stall_pct = 24;
        end
      endcase
      for (int n = 0; n < PHASE_REQUESTS; n++) offer_day(pick_day());
    end
    day_valid <= 1'b0;

    // The checker's pending count is registered, so step before testing it.
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== civil_date_from_day_count_unit.f =====
src/cdfd_pkg.sv
src/cdfd_const_div.sv
src/civil_date_from_day_count_unit.sv
src/cdfd_checker.sv
test/civil_date_checker.sv
test/tb_civil_date_from_day_count_unit.sv
